// ===== hdl/hrgb_pkg.sv =====
// shared types and constants for the half/single rgba to single rgb converter
// no dependencies
`timescale 1ns / 1ps

package hrgb_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned DIM_W   = 15;
    localparam int unsigned COUNT_W = 29;
    localparam int unsigned TOTAL_W = 2 * DIM_W;
    localparam int unsigned BYTES_W = TOTAL_W + 4;
    localparam int unsigned PADDR_W = 4;

    // largest allowed frame width or height
    localparam logic [16:0] MAX_EXTENT = 17'd16384;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [DATA_W-1:0]  MAX_BYTES_RESET = 32'h1000_0000;

    typedef enum logic [1:0] {
        REG_ENCODING  = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_MAX_BYTES = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EXTENT = 2'd1,
        STATUS_COUNT  = 2'd2
    } status_t;

    // per-pixel findings of the frame checker
    typedef struct packed {
        logic frame_end;
        logic extent_bad;
        logic count_bad;
    } chk_flags_t;

endpackage

// ===== hdl/hrgb_lane.sv =====
// one channel lane: half to single widening or single pass-through, registered
// depends on hrgb_pkg
`timescale 1ns / 1ps

module hrgb_lane (
    input  logic                       aclk,
    input  logic                       load,
    input  logic                       encoding,
    input  logic [hrgb_pkg::DATA_W-1:0] chan,
    output logic [hrgb_pkg::DATA_W-1:0] result
);

    logic [hrgb_pkg::DATA_W-1:0] result_reg;
    logic [hrgb_pkg::DATA_W-1:0] result_next;
    logic                        sign;
    logic [4:0]                  expo;
    logic [9:0]                  mant;
    logic [3:0]                  msb_pos;
    logic [3:0]                  shift;
    logic [10:0]                 norm_wide;
    logic [7:0]                  sub_expo;
    logic [7:0]                  norm_expo;

    always_comb begin
        sign  = chan[15];
        expo  = chan[14:10];
        mant  = chan[9:0];

        // highest set mantissa bit of a subnormal
        msb_pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (mant[i]) begin
                msb_pos = 4'(i);
            end
        end
        shift     = 4'd10 - msb_pos;
        norm_wide = {1'b0, mant} << shift;
        sub_expo  = 8'd103 + {4'b0000, msb_pos};
        norm_expo = {3'b000, expo} + 8'd112;

        if (encoding) begin
            result_next = chan;
        end else if (expo == 5'd0) begin
            if (mant == 10'd0) begin
                result_next = {sign, 31'd0};
            end else begin
                result_next = {sign, sub_expo, norm_wide[9:0], 13'd0};
            end
        end else if (expo == 5'h1f) begin
            result_next = {sign, 8'hff, mant, 13'd0};
        end else begin
            result_next = {sign, norm_expo, mant, 13'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/hrgb_check.sv =====
// frame checker: extent and byte limit, pixel counting and count mismatch
// depends on hrgb_pkg
`timescale 1ns / 1ps

module hrgb_check #(
    parameter logic [16:0] MAX_EXTENT = hrgb_pkg::MAX_EXTENT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          last,
    input  logic                          encoding,
    input  logic [hrgb_pkg::DIM_W-1:0]    frame_width,
    input  logic [hrgb_pkg::DIM_W-1:0]    frame_height,
    input  logic [hrgb_pkg::DATA_W-1:0]   max_bytes,
    output hrgb_pkg::chk_flags_t          flags
);

    logic [hrgb_pkg::COUNT_W-1:0] count_reg;
    logic [hrgb_pkg::COUNT_W-1:0] count_next;
    logic [hrgb_pkg::COUNT_W-1:0] seen;
    logic [hrgb_pkg::TOTAL_W-1:0] total;
    logic [hrgb_pkg::BYTES_W-1:0] bytes;
    logic                         dim_bad;

    logic [hrgb_pkg::TOTAL_W-1:0] total_reg;
    logic [hrgb_pkg::BYTES_W-1:0] bytes_reg;
    logic [hrgb_pkg::DATA_W-1:0]  limit_reg;
    logic [hrgb_pkg::COUNT_W-1:0] seen_reg;
    logic                         dim_bad_reg;
    logic                         last_reg;
    logic [hrgb_pkg::TOTAL_W-1:0] seen_wide;

    always_comb begin
        seen  = (count_reg == hrgb_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
        total = {15'd0, frame_width} * {15'd0, frame_height};
        bytes = encoding ? {total, 4'b0000} : {1'b0, total, 3'b000};
        dim_bad = (frame_width == '0) || (frame_height == '0)
               || ({2'b00, frame_width} > MAX_EXTENT)
               || ({2'b00, frame_height} > MAX_EXTENT)
               || (max_bytes == '0);
        if (load) begin
            count_next = last ? '0 : seen;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            total_reg   <= total;
            bytes_reg   <= bytes;
            limit_reg   <= max_bytes;
            seen_reg    <= seen;
            dim_bad_reg <= dim_bad;
            last_reg    <= last;
        end
    end

    always_comb begin
        seen_wide        = {1'b0, seen_reg};
        flags.frame_end  = last_reg;
        flags.extent_bad = dim_bad_reg || (bytes_reg > {2'b00, limit_reg});
        flags.count_bad  = last_reg ? (seen_wide != total_reg) : (seen_wide > total_reg);
    end

`ifndef SYNTHESIS
    a_count_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && last) |=> (count_reg == '0))
        else $error("pixel count not cleared after frame end");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !last && count_reg != hrgb_pkg::COUNT_MAX)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("pixel count did not advance by one");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !last && count_reg == hrgb_pkg::COUNT_MAX)
        |=> (count_reg == hrgb_pkg::COUNT_MAX))
        else $error("pixel count wrapped");
`endif

endmodule

// ===== hdl/half_rgba_to_float_rgb_unit.sv =====
// one pixel per cycle sustained while the result side keeps m_ready high
// stage one runs three channel lanes and the extent multiply side by side, stage two
// merges lane data with the checker status in the output register
// a new transfer is taken while a result waits, up to one pixel held in each stage
// aresetn is synchronous active low: clears valids, pixel count and config to defaults
`timescale 1ns / 1ps

module half_rgba_to_float_rgb_unit #(
    parameter logic [16:0] MAX_EXTENT = hrgb_pkg::MAX_EXTENT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hrgb_pkg::PADDR_W-1:0]       paddr,
    input  logic [hrgb_pkg::DATA_W-1:0]        pwdata,
    output logic [hrgb_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [hrgb_pkg::DATA_W-1:0]        s_chan_red,
    input  logic [hrgb_pkg::DATA_W-1:0]        s_chan_green,
    input  logic [hrgb_pkg::DATA_W-1:0]        s_chan_blue,
    input  logic                               s_last_pixel,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hrgb_pkg::DATA_W-1:0]        m_out_red,
    output logic [hrgb_pkg::DATA_W-1:0]        m_out_green,
    output logic [hrgb_pkg::DATA_W-1:0]        m_out_blue,
    output logic                               m_frame_end,
    output logic [1:0]                         m_status
);

    logic                          encoding_reg;
    logic [hrgb_pkg::DIM_W-1:0]    width_reg;
    logic [hrgb_pkg::DIM_W-1:0]    height_reg;
    logic [hrgb_pkg::DATA_W-1:0]   max_bytes_reg;
    logic                          cfg_write;
    hrgb_pkg::reg_index_t          reg_sel;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic                          out_free;
    logic                          load;
    logic                          out_load;

    logic [hrgb_pkg::DATA_W-1:0]   lane_red;
    logic [hrgb_pkg::DATA_W-1:0]   lane_green;
    logic [hrgb_pkg::DATA_W-1:0]   lane_blue;
    hrgb_pkg::chk_flags_t          flags;
    hrgb_pkg::status_t             status_next;

    logic [hrgb_pkg::DATA_W-1:0]   red_reg;
    logic [hrgb_pkg::DATA_W-1:0]   green_reg;
    logic [hrgb_pkg::DATA_W-1:0]   blue_reg;
    logic                          frame_end_reg;
    hrgb_pkg::status_t             status_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = hrgb_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encoding_reg  <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            max_bytes_reg <= hrgb_pkg::MAX_BYTES_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                hrgb_pkg::REG_ENCODING:  encoding_reg  <= pwdata[0];
                hrgb_pkg::REG_WIDTH:     width_reg     <= pwdata[hrgb_pkg::DIM_W-1:0];
                hrgb_pkg::REG_HEIGHT:    height_reg    <= pwdata[hrgb_pkg::DIM_W-1:0];
                hrgb_pkg::REG_MAX_BYTES: max_bytes_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            hrgb_pkg::REG_ENCODING:  prdata = {31'd0, encoding_reg};
            hrgb_pkg::REG_WIDTH:     prdata = {17'd0, width_reg};
            hrgb_pkg::REG_HEIGHT:    prdata = {17'd0, height_reg};
            hrgb_pkg::REG_MAX_BYTES: prdata = max_bytes_reg;
            default:                 prdata = '0;
        endcase
    end

    // two-stage flow control
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign load     = s_valid && s_ready;
    assign out_load = s1_valid_reg && out_free;

    always_comb begin
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    hrgb_lane u_lane_red (
        .aclk     (aclk),
        .load     (load),
        .encoding (encoding_reg),
        .chan     (s_chan_red),
        .result   (lane_red)
    );

    hrgb_lane u_lane_green (
        .aclk     (aclk),
        .load     (load),
        .encoding (encoding_reg),
        .chan     (s_chan_green),
        .result   (lane_green)
    );

    hrgb_lane u_lane_blue (
        .aclk     (aclk),
        .load     (load),
        .encoding (encoding_reg),
        .chan     (s_chan_blue),
        .result   (lane_blue)
    );

    hrgb_check #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .last         (s_last_pixel),
        .encoding     (encoding_reg),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .max_bytes    (max_bytes_reg),
        .flags        (flags)
    );

    // merge: a bad extent blanks the pixel and wins over a count mismatch
    always_comb begin
        priority if (flags.extent_bad) begin
            status_next = hrgb_pkg::STATUS_EXTENT;
        end else if (flags.count_bad) begin
            status_next = hrgb_pkg::STATUS_COUNT;
        end else begin
            status_next = hrgb_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            red_reg       <= flags.extent_bad ? '0 : lane_red;
            green_reg     <= flags.extent_bad ? '0 : lane_green;
            blue_reg      <= flags.extent_bad ? '0 : lane_blue;
            frame_end_reg <= flags.frame_end;
            status_reg    <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = red_reg;
    assign m_out_green = green_reg;
    assign m_out_blue  = blue_reg;
    assign m_frame_end = frame_end_reg;
    assign m_status    = status_reg;

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are full");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_free) |=> m_valid_reg)
        else $error("stage one pixel lost on the way to the output");

    a_extent_blanks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == hrgb_pkg::STATUS_EXTENT)
        |-> (red_reg == '0 && green_reg == '0 && blue_reg == '0))
        else $error("pixel not blanked on bad extent");
`endif

endmodule

// ===== tb/half_rgba_to_float_rgb_unit_tb.sv =====
// testbench for half_rgba_to_float_rgb_unit: pixel conversion, extent check and pixel count
// depends on hrgb_pkg and the unit; a scoreboard class predicts each pixel result
`timescale 1ns / 1ps

typedef struct {
    logic [31:0]       red;
    logic [31:0]       green;
    logic [31:0]       blue;
    logic              frame_end;
    hrgb_pkg::status_t status;
} rgb_result_t;

class pixel_scoreboard;
    logic                           encoding;
    logic [hrgb_pkg::DIM_W-1:0]     frame_width;
    logic [hrgb_pkg::DIM_W-1:0]     frame_height;
    logic [31:0]                    max_bytes;
    logic [hrgb_pkg::COUNT_W-1:0]   pixel_count;
    rgb_result_t                    expected_q[$];
    int                             errors;

    function new();
        encoding     = 1'b0;
        frame_width  = '0;
        frame_height = '0;
        max_bytes    = hrgb_pkg::MAX_BYTES_RESET;
        pixel_count  = '0;
        errors       = 0;
    endfunction

    function void write_reg(hrgb_pkg::reg_index_t idx, logic [31:0] value);
        case (idx)
            hrgb_pkg::REG_ENCODING:  encoding = value[0];
            hrgb_pkg::REG_WIDTH:     frame_width = value[hrgb_pkg::DIM_W-1:0];
            hrgb_pkg::REG_HEIGHT:    frame_height = value[hrgb_pkg::DIM_W-1:0];
            hrgb_pkg::REG_MAX_BYTES: max_bytes = value;
            default: ;
        endcase
    endfunction

    function bit extent_bad();
        logic [63:0] bytes;
        if (frame_width == 0 || frame_height == 0)
            return 1'b1;
        if (frame_width > hrgb_pkg::MAX_EXTENT || frame_height > hrgb_pkg::MAX_EXTENT)
            return 1'b1;
        if (max_bytes == 0)
            return 1'b1;
        bytes = 64'(frame_width) * 64'(frame_height) * (encoding ? 64'd16 : 64'd8);
        return bytes > 64'(max_bytes);
    endfunction

    function logic [31:0] half_to_single(logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  expo;
        logic [10:0] mant;
        int          shifts;
        sign   = {h[15], 31'b0};
        expo   = h[14:10];
        mant   = {1'b0, h[9:0]};
        shifts = 0;
        if (expo == 5'd0) begin
            if (mant == 0)
                return sign;
            // subnormal: normalize until the hidden bit shows up
            while (!mant[10] && shifts < 11) begin
                mant   = mant << 1;
                shifts = shifts + 1;
            end
            return sign | (32'(113 - shifts) << 23) | (32'(mant[9:0]) << 13);
        end
        if (expo == 5'h1f)
            return sign | 32'h7f80_0000 | (32'(mant[9:0]) << 13);
        return sign | ((32'(expo) + 32'd112) << 23) | (32'(mant[9:0]) << 13);
    endfunction

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic last);
        rgb_result_t res;
        logic [63:0] total;
        logic [63:0] seen;
        total = 64'(frame_width) * 64'(frame_height);
        if (pixel_count != hrgb_pkg::COUNT_MAX)
            pixel_count = pixel_count + 1'b1;
        seen = 64'(pixel_count);
        if (encoding == 1'b0) begin
            res.red   = half_to_single(r[15:0]);
            res.green = half_to_single(g[15:0]);
            res.blue  = half_to_single(b[15:0]);
        end else begin
            res.red   = r;
            res.green = g;
            res.blue  = b;
        end
        res.frame_end = last;
        res.status    = hrgb_pkg::STATUS_OK;
        if (extent_bad()) begin
            res.status = hrgb_pkg::STATUS_EXTENT;
            res.red    = '0;
            res.green  = '0;
            res.blue   = '0;
        end else if (last ? (seen != total) : (seen > total)) begin
            res.status = hrgb_pkg::STATUS_COUNT;
        end
        expected_q.push_back(res);
        if (last)
            pixel_count = '0;
    endfunction

    function void check_result(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                               logic fe, logic [1:0] st);
        rgb_result_t exp_res;
        logic [31:0] exp_v[5];
        logic [31:0] got_v[5];
        string       field_name[5] = '{"out_red", "out_green", "out_blue", "frame_end", "status"};
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result red=%h green=%h blue=%h frame_end=%b status=%0d",
                     $time, r, g, b, fe, st);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        exp_v = '{exp_res.red, exp_res.green, exp_res.blue,
                  32'(exp_res.frame_end), 32'(exp_res.status)};
        got_v = '{r, g, b, 32'(fe), 32'(st)};
        for (int i = 0; i < 5; i++) begin
            if (got_v[i] !== exp_v[i]) begin
                $display("%0t: %s mismatch: expected %h actual %h",
                         $time, field_name[i], exp_v[i], got_v[i]);
                errors++;
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module half_rgba_to_float_rgb_unit_tb;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [hrgb_pkg::PADDR_W-1:0] paddr;
    logic [hrgb_pkg::DATA_W-1:0]  pwdata;
    logic [hrgb_pkg::DATA_W-1:0]  prdata;
    logic                         pready;
    logic                         s_valid;
    logic                         s_ready;
    logic [hrgb_pkg::DATA_W-1:0]  s_chan_red;
    logic [hrgb_pkg::DATA_W-1:0]  s_chan_green;
    logic [hrgb_pkg::DATA_W-1:0]  s_chan_blue;
    logic                         s_last_pixel;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [hrgb_pkg::DATA_W-1:0]  m_out_red;
    logic [hrgb_pkg::DATA_W-1:0]  m_out_green;
    logic [hrgb_pkg::DATA_W-1:0]  m_out_blue;
    logic                         m_frame_end;
    logic [1:0]                   m_status;

    pixel_scoreboard sb = new();

    int items_sent = 0;
    int tx_burst   = 0;
    int rx_calm    = 0;
    int rx_stall   = 0;

    half_rgba_to_float_rgb_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chan_red   (s_chan_red),
        .s_chan_green (s_chan_green),
        .s_chan_blue  (s_chan_blue),
        .s_last_pixel (s_last_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_frame_end  (m_frame_end),
        .m_status     (m_status)
    );

    always #1 aclk = ~aclk;

    // result side back-pressure: calm stretches, short stalls and a few long ones
    always @(negedge aclk) begin
        int k;
        if (rx_calm > 0) begin
            rx_calm--;
            m_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            k = $urandom_range(0, 99);
            if (k < 3)
                rx_calm = $urandom_range(20, 80);
            else if (k < 25)
                rx_stall = $urandom_range(1, 3);
            else if (k < 28)
                rx_stall = $urandom_range(10, 40);
            m_ready <= (rx_stall == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_red, m_out_green, m_out_blue, m_frame_end, m_status);
    end

    function automatic int next_gap();
        int k;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        k = $urandom_range(0, 99);
        if (k < 4) begin
            tx_burst = $urandom_range(20, 60);
            return 0;
        end
        if (k < 55)
            return 0;
        if (k < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // half-float biased toward zero and all-ones exponents and empty mantissas
    function automatic logic [31:0] rand_chan();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[14:10] = '0;
            1: v[14:10] = '1;
            2: v[9:0] = '0;
            3: begin
                v[14:10] = '0;
                v[9:0]   = '0;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(hrgb_pkg::reg_index_t idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // junk fills the unused upper bits of the narrow registers
    task automatic set_frame(logic enc, logic [31:0] w, logic [31:0] h, logic [31:0] mb,
                             bit junk);
        logic [31:0] ev;
        logic [31:0] wv;
        logic [31:0] hv;
        ev = junk ? $urandom : 32'd0;
        wv = junk ? $urandom : 32'd0;
        hv = junk ? $urandom : 32'd0;
        ev[0]       = enc;
        wv[hrgb_pkg::DIM_W-1:0] = w[hrgb_pkg::DIM_W-1:0];
        hv[hrgb_pkg::DIM_W-1:0] = h[hrgb_pkg::DIM_W-1:0];
        write_reg(hrgb_pkg::REG_ENCODING, ev);
        write_reg(hrgb_pkg::REG_WIDTH, wv);
        write_reg(hrgb_pkg::REG_HEIGHT, hv);
        write_reg(hrgb_pkg::REG_MAX_BYTES, mb);
    endtask

    task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b, logic last);
        int gap;
        gap = next_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_chan_red   <= r;
        s_chan_green <= g;
        s_chan_blue  <= b;
        s_last_pixel <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(r, g, b, last);
        items_sent++;
    endtask

    task automatic send_frame(int n, bit with_last);
        for (int i = 1; i <= n; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), with_last && (i == n));
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          kind;
        int          nf;
        int          n;
        int          k;
        logic        enc;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] mb;
        longint      bytes;
        longint      total;

        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_chan_red   = '0;
        s_chan_green = '0;
        s_chan_blue  = '0;
        s_last_pixel = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config has zero extent
        send_pixel(32'h0000_3c00, 32'h0000_4000, 32'h0000_c000, 1'b1);
        wait_idle();

        // 3x2 half frame carrying the special encodings
        set_frame(1'b0, 3, 2, 32'hffff_ffff, 1'b0);
        send_pixel(32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 1'b0);
        send_pixel(32'h0000_03ff, 32'h0000_0400, 32'h0000_7bff, 1'b0);
        send_pixel(32'h0000_7c00, 32'h0000_fc00, 32'h0000_7e00, 1'b0);
        send_pixel(32'h0000_7c01, 32'h0000_ffff, 32'h0000_8001, 1'b0);
        send_pixel(32'hdead_3c00, 32'hffff_0000, 32'h1234_5555, 1'b0);
        send_pixel(32'h0000_0200, 32'h0000_83ff, 32'h0000_fbff, 1'b1);
        // frame ends early, then runs long
        send_frame(2, 1'b1);
        send_frame(8, 1'b1);
        wait_idle();

        // single mode passes bits through; 16 bytes exactly at the limit
        set_frame(1'b1, 1, 1, 32'd16, 1'b1);
        send_pixel(32'hffff_ffff, 32'h0000_0000, 32'h7fc0_0001, 1'b1);
        wait_idle();
        set_frame(1'b1, 1, 1, 32'd15, 1'b0);
        send_pixel(32'h3f80_0000, 32'hbf80_0000, 32'h7f80_0000, 1'b1);
        wait_idle();
        set_frame(1'b0, 16384, 16384, 32'hffff_ffff, 1'b0);
        send_pixel(32'h0000_3c00, 32'h0000_3c00, 32'h0000_3c00, 1'b1);
        wait_idle();
        set_frame(1'b1, 16384, 16384, 32'hffff_ffff, 1'b0);
        send_pixel(32'h3f80_0000, 32'h3f80_0000, 32'h3f80_0000, 1'b1);
        wait_idle();
        set_frame(1'b0, 16385, 1, 32'hffff_ffff, 1'b0);
        send_pixel(32'h0000_3c00, 32'h0000_3c00, 32'h0000_3c00, 1'b1);
        wait_idle();
        set_frame(1'b0, 2, 1, 32'h0000_0000, 1'b0);
        send_frame(2, 1'b1);
        wait_idle();
        set_frame(1'b0, 32767, 0, 32'hffff_ffff, 1'b0);
        send_frame(1, 1'b1);

        while (items_sent < 530) begin
            wait_idle();
            kind = $urandom_range(0, 9);
            enc  = $urandom_range(0, 1);
            w    = $urandom_range(1, 5);
            h    = $urandom_range(1, 5);
            bytes = longint'(w) * longint'(h) * (enc ? 16 : 8);
            if (kind <= 5) begin
                k = $urandom_range(0, 2);
                if (k == 0)
                    mb = 32'hffff_ffff;
                else if (k == 1)
                    mb = 32'(bytes);
                else
                    mb = 32'(bytes) + $urandom_range(0, 1000);
            end else if (kind == 6) begin
                w  = 16384;
                h  = $urandom_range(1, 16383);
                mb = 32'hffff_ffff;
            end else if (kind == 7) begin
                mb = 32'(bytes) - 1;
            end else if (kind == 8) begin
                w  = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(16385, 32767));
                h  = $urandom_range(0, 32767);
                mb = $urandom;
            end else begin
                mb = 32'd0;
            end
            set_frame(enc, w, h, mb, bit'($urandom_range(0, 1)));

            total = longint'(w[hrgb_pkg::DIM_W-1:0]) * longint'(h[hrgb_pkg::DIM_W-1:0]);
            nf = $urandom_range(2, 5);
            for (int f = 0; f < nf; f++) begin
                k = $urandom_range(0, 9);
                if (total >= 1 && total <= 25 && k < 8)
                    n = int'(total);
                else if (total >= 1 && total <= 25 && k == 8)
                    n = int'(total) + $urandom_range(1, 3);
                else
                    n = $urandom_range(1, 8);
                send_frame(n, 1'b1);
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
            end
            // sometimes leave a partial frame so the count carries into the next setting
            if ($urandom_range(0, 9) == 0)
                send_frame($urandom_range(1, 3), 1'b0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
